@@ rtl/tcpu_pkg.sv @@
package tcpu_pkg;

	// opcodes, instruction bits 14:11
	localparam logic [3:0] OP_MOV = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_AND = 4'd3;
	localparam logic [3:0] OP_OR  = 4'd4;
	localparam logic [3:0] OP_SL  = 4'd5;
	localparam logic [3:0] OP_SR  = 4'd6;
	localparam logic [3:0] OP_SRA = 4'd7;
	localparam logic [3:0] OP_LDL = 4'd8;
	localparam logic [3:0] OP_LDH = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_JE  = 4'd11;
	localparam logic [3:0] OP_JMP = 4'd12;
	localparam logic [3:0] OP_LD  = 4'd13;
	localparam logic [3:0] OP_ST  = 4'd14;
	localparam logic [3:0] OP_HLT = 4'd15;

	// write kind codes carried in the result
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_MEM  = 2'd2;

	localparam int REG_COUNT = 8;
	localparam int REG_AW    = 3;
	localparam int WORD_W    = 16;
	localparam int PC_W      = 8;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	// one decoded instruction held in the execute stage
	typedef struct packed {
		logic [3:0]        opc;
		logic [REG_AW-1:0] ra;
		logic [7:0]        imm;
	} instr_t;

	// one result item
	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              equal_flag;
		logic [1:0]        write_kind;
		logic [7:0]        write_target;
		logic [WORD_W-1:0] write_value;
		logic              halted;
	} result_t;

endpackage

@@ rtl/teaching_cpu_execute_step_top.sv @@
// Channel   Dir  Width  Contents
// s_*       in   16     tdata: instruction[14:0], zero pad[15]
// m_*       out  40+2   tdata: next_pc, equal_flag, write_target, write_value, halted
//                       tuser: write_kind
//
// One instruction per clock sustained while m_tready is high: accept loads the execute stage
// and starts the register file and data RAM reads; the instruction then executes into the
// result register once that register is empty or its result is being taken.
// A write from the executing instruction is forwarded to the reads of the instruction
// accepted at the same edge. Reset clears state at once through per-entry valid bits.
// A stalled result holds the execute stage; s_tready follows m_tready through it.
module teaching_cpu_execute_step_top #(
	parameter int DATA_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tcpu_pkg::IN_TDATA_W-1:0]    s_tdata,   // [14:0] instruction, [15] pad
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] next_pc, [8] equal_flag, [16:9] write_target, [32:17] write_value,
	// [33] halted, [39:34] pad
	output logic [tcpu_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic [1:0]                         m_tuser    // [1:0] write_kind
);

	import tcpu_pkg::*;

	localparam int DAW = $clog2(DATA_DEPTH);

	// input decode
	logic              s_xfer;
	logic [3:0]        in_opc;
	logic [REG_AW-1:0] in_ra;
	logic [REG_AW-1:0] in_rb;
	logic [7:0]        in_imm;

	assign s_xfer = s_tvalid && s_tready;
	assign in_opc = s_tdata[14:11];
	assign in_ra  = s_tdata[10:8];
	assign in_rb  = s_tdata[7:5];
	assign in_imm = s_tdata[7:0];

	// execute stage
	logic              valid_s1;
	instr_t            instr_s1;
	logic              a_hit_s1, b_hit_s1, m_hit_s1;
	logic              a_vld_s1, b_vld_s1, m_vld_s1;
	logic [WORD_W-1:0] a_byp_s1, b_byp_s1, m_byp_s1;

	// architectural state
	logic [PC_W-1:0]       pc_q;
	logic                  eq_q;
	logic                  halt_q;
	logic [REG_COUNT-1:0]  reg_vld_q;
	logic [DATA_DEPTH-1:0] dm_vld_q;

	// result register
	logic    out_valid_q;
	result_t out_q;

	logic              exec;
	logic [WORD_W-1:0] ram_a, ram_b, ram_m;
	logic [WORD_W-1:0] a, b, mval;
	result_t           res;
	logic              eq_nx, halt_nx;
	logic              wr_reg, wr_mem;

	assign exec     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || exec;

	// operand select: forwarded, stored, or reset value
	always_comb begin
		a    = a_hit_s1 ? a_byp_s1 : (a_vld_s1 ? ram_a : '0);
		b    = b_hit_s1 ? b_byp_s1 : (b_vld_s1 ? ram_b : '0);
		mval = m_hit_s1 ? m_byp_s1 : (m_vld_s1 ? ram_m : '0);
	end

	// execute
	always_comb begin
		logic [WORD_W-1:0] val;
		logic [1:0]        kind;
		val     = '0;
		kind    = KIND_NONE;
		eq_nx   = eq_q;
		halt_nx = halt_q;
		res.next_pc = pc_q + PC_W'(1);
		case (instr_s1.opc)
			OP_MOV: begin val = b;                           kind = KIND_REG; end
			OP_ADD: begin val = a + b;                       kind = KIND_REG; end
			OP_SUB: begin val = a - b;                       kind = KIND_REG; end
			OP_AND: begin val = a & b;                       kind = KIND_REG; end
			OP_OR:  begin val = a | b;                       kind = KIND_REG; end
			OP_SL:  begin val = {a[14:0], 1'b0};             kind = KIND_REG; end
			OP_SR:  begin val = {1'b0, a[15:1]};             kind = KIND_REG; end
			OP_SRA: begin val = {a[15], a[15:1]};            kind = KIND_REG; end
			OP_LDL: begin val = {a[15:8], instr_s1.imm};     kind = KIND_REG; end
			OP_LDH: begin val = {instr_s1.imm, a[7:0]};      kind = KIND_REG; end
			OP_CMP: eq_nx = (a == b);
			OP_JE:  if (eq_q) res.next_pc = instr_s1.imm;
			OP_JMP: res.next_pc = instr_s1.imm;
			OP_LD:  begin val = mval;                        kind = KIND_REG; end
			OP_ST:  begin val = a;                           kind = KIND_MEM; end
			default: halt_nx = 1'b1;
		endcase
		res.write_kind = kind;
		res.write_value = (kind == KIND_NONE) ? '0 : val;
		case (kind)
			KIND_REG: res.write_target = 8'(instr_s1.ra);
			KIND_MEM: res.write_target = instr_s1.imm;
			default:  res.write_target = '0;
		endcase
		res.equal_flag = eq_nx;
		res.halted     = halt_nx;
		// halted core holds everything
		if (halt_q) begin
			res.next_pc      = pc_q;
			res.equal_flag   = eq_q;
			res.write_kind   = KIND_NONE;
			res.write_target = '0;
			res.write_value  = '0;
			res.halted       = 1'b1;
			eq_nx            = eq_q;
			halt_nx          = 1'b1;
		end
	end

	assign wr_reg = exec && (res.write_kind == KIND_REG);
	assign wr_mem = exec && (res.write_kind == KIND_MEM);

	// register file, two copies for the two read ports
	tcpu_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (wr_reg),
		.waddr (instr_s1.ra),
		.wdata (res.write_value),
		.re    (s_xfer),
		.raddr (in_ra),
		.rdata (ram_a)
	);

	tcpu_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (wr_reg),
		.waddr (instr_s1.ra),
		.wdata (res.write_value),
		.re    (s_xfer),
		.raddr (in_rb),
		.rdata (ram_b)
	);

	// data RAM
	tcpu_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_dm (
		.clk   (clk),
		.we    (wr_mem),
		.waddr (instr_s1.imm[DAW-1:0]),
		.wdata (res.write_value),
		.re    (s_xfer),
		.raddr (in_imm[DAW-1:0]),
		.rdata (ram_m)
	);

	// execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// execute stage payload, forwarding and valid snapshots taken on accept
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			instr_s1.opc <= in_opc;
			instr_s1.ra  <= in_ra;
			instr_s1.imm <= in_imm;
			a_hit_s1 <= wr_reg && (instr_s1.ra == in_ra);
			b_hit_s1 <= wr_reg && (instr_s1.ra == in_rb);
			m_hit_s1 <= wr_mem && (instr_s1.imm[DAW-1:0] == in_imm[DAW-1:0]);
			a_byp_s1 <= res.write_value;
			b_byp_s1 <= res.write_value;
			m_byp_s1 <= res.write_value;
			a_vld_s1 <= reg_vld_q[in_ra];
			b_vld_s1 <= reg_vld_q[in_rb];
			m_vld_s1 <= dm_vld_q[in_imm[DAW-1:0]];
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			eq_q      <= 1'b0;
			halt_q    <= 1'b0;
			reg_vld_q <= '0;
			dm_vld_q  <= '0;
		end else if (exec) begin
			pc_q   <= res.next_pc;
			eq_q   <= eq_nx;
			halt_q <= halt_nx;
			if (wr_reg) begin
				reg_vld_q[instr_s1.ra] <= 1'b1;
			end
			if (wr_mem) begin
				dm_vld_q[instr_s1.imm[DAW-1:0]] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.write_kind;
	assign m_tdata  = {6'b0, out_q.halted, out_q.write_value, out_q.write_target,
	                   out_q.equal_flag, out_q.next_pc};

endmodule

@@ rtl/tcpu_ram.sv @@
module tcpu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tcpu_checker.sv @@
module tcpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	import tcpu_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only defined write kinds appear
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_NONE || m_tuser == KIND_REG || m_tuser == KIND_MEM))
		else $error("undefined write kind");

	// a halted core writes nothing
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tuser == KIND_NONE)
		else $error("write reported while halted");

	// register target within the register file, no write means zero fields
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_REG |-> m_tdata[16:12] == 5'd0)
		else $error("register target out of range");

	a_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tdata[32:9] == 24'd0)
		else $error("nonzero write fields without a write");

endmodule

bind teaching_cpu_execute_step_top tcpu_checker u_tcpu_checker (.*);
